/* hw/rtl/i2ra_pkg.sv */
// Shared types, constants and helper functions for the integer-to-radix converter.
// No dependencies; used by i2ra_divider, i2ra_digit_stack and the core.
`timescale 1ns / 1ps
`default_nettype none

package i2ra_pkg;

   localparam int VALUE_BITS      = 31;
   localparam int STEP_BITS       = 4;
   localparam int WORK_BITS       = ((VALUE_BITS + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
   localparam int STEPS_PER_DIGIT = WORK_BITS / STEP_BITS;
   localparam int STEP_CNT_BITS   = $clog2(STEPS_PER_DIGIT);

   localparam int RADIX_BITS = 6;
   localparam int DIGIT_BITS = 6;
   localparam int CHAR_BITS  = 7;

   localparam int STACK_DEPTH = VALUE_BITS;
   localparam int PTR_BITS    = $clog2(STACK_DEPTH);
   localparam int COUNT_BITS  = $clog2(STACK_DEPTH + 1);

   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;

   localparam logic [DIGIT_BITS-1:0] DIGIT_NINE    = 6'd9;
   localparam logic [DIGIT_BITS-1:0] DIGIT_TEN     = 6'd10;
   localparam logic [CHAR_BITS-1:0]  CHAR_ZERO     = 7'd48;
   localparam logic [CHAR_BITS-1:0]  CHAR_LETTER_A = 7'd65;

   typedef struct packed {
      logic                  done;
      logic [WORK_BITS-1:0]  quotient;
      logic [DIGIT_BITS-1:0] remainder;
   } div_result_type;

   typedef struct packed {
      logic                  valid;
      logic [DIGIT_BITS-1:0] digit;
      logic                  last;
   } stack_read_type;

   // Clamp the programmed radix into the legal 2..36 range.
   function automatic logic [RADIX_BITS-1:0] effective_radix(input logic [RADIX_BITS-1:0] r);
      logic [RADIX_BITS-1:0] res;
      if (r < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         res = RADIX_MAX;
      end else begin
         res = r;
      end
      return res;
   endfunction

   function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] res;
      if (d <= DIGIT_NINE) begin
         res = CHAR_ZERO + CHAR_BITS'(d);
      end else begin
         res = CHAR_LETTER_A + CHAR_BITS'(d - DIGIT_TEN);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/i2ra_divider.sv */
// Iterative restoring divider: a word divided by a narrow divisor, STEP_BITS quotient bits
// a cycle. Depends on i2ra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2ra_divider (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [i2ra_pkg::WORK_BITS-1:0]    dividend,
   input  wire logic [i2ra_pkg::RADIX_BITS-1:0]   divisor,
   output i2ra_pkg::div_result_type               result
);

   logic [i2ra_pkg::WORK_BITS-1:0]     work_ff, work_in;
   logic [i2ra_pkg::DIGIT_BITS-1:0]    rem_ff, rem_in;
   logic [i2ra_pkg::STEP_CNT_BITS-1:0] count_ff, count_in;
   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;

   logic [i2ra_pkg::WORK_BITS-1:0]  step_work;
   logic [i2ra_pkg::DIGIT_BITS-1:0] step_rem;
   logic [i2ra_pkg::DIGIT_BITS:0]   trial;

   // Shift-subtract over STEP_BITS quotient bits; remainder stays below the divisor.
   always_comb begin
      step_work = work_ff;
      step_rem  = rem_ff;
      trial     = '0;
      for (int i = 0; i < i2ra_pkg::STEP_BITS; i++) begin
         trial     = {step_rem, step_work[i2ra_pkg::WORK_BITS-1]};
         step_work = {step_work[i2ra_pkg::WORK_BITS-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            step_rem     = i2ra_pkg::DIGIT_BITS'(trial - {1'b0, divisor});
            step_work[0] = 1'b1;
         end else begin
            step_rem = trial[i2ra_pkg::DIGIT_BITS-1:0];
         end
      end
   end

   always_comb begin
      work_in  = work_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         work_in  = dividend;
         rem_in   = '0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         work_in  = step_work;
         rem_in   = step_rem;
         count_in = count_ff + 1'b1;
         if (count_ff == i2ra_pkg::STEP_CNT_BITS'(i2ra_pkg::STEPS_PER_DIGIT - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   assign result.done      = done_ff;
   assign result.quotient  = work_ff;
   assign result.remainder = rem_ff;

   // A new division must never cut into one in flight.
   a_no_restart_while_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

endmodule

`default_nettype wire

/* hw/rtl/i2ra_digit_stack.sv */
// Last-in first-out store of digit values, least significant pushed first.
// Depends on i2ra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2ra_digit_stack (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               push,
   input  wire logic [i2ra_pkg::DIGIT_BITS-1:0]    push_digit,
   input  wire logic                               pop,
   output logic [i2ra_pkg::COUNT_BITS-1:0]         count,
   output i2ra_pkg::stack_read_type                rd
);

   logic [i2ra_pkg::DIGIT_BITS-1:0] mem [i2ra_pkg::STACK_DEPTH];

   logic [i2ra_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic                            valid_ff;
   logic                            last_ff;
   logic [i2ra_pkg::DIGIT_BITS-1:0] data_ff;
   logic [i2ra_pkg::PTR_BITS-1:0]   wr_addr;
   logic [i2ra_pkg::PTR_BITS-1:0]   rd_addr;

   assign wr_addr = count_ff[i2ra_pkg::PTR_BITS-1:0];
   assign rd_addr = i2ra_pkg::PTR_BITS'(count_ff - 1'b1);

   always_comb begin
      count_in = count_ff;
      if (push) begin
         count_in = count_ff + 1'b1;
      end else if (pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_addr] <= push_digit;
      end
      data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= pop;
         last_ff  <= pop && (count_ff == i2ra_pkg::COUNT_BITS'(1));
      end
   end

   assign count    = count_ff;
   assign rd.valid = valid_ff;
   assign rd.digit = data_ff;
   assign rd.last  = last_ff;

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != i2ra_pkg::COUNT_BITS'(i2ra_pkg::STACK_DEPTH)))
      else $error("digit stack overflow");

endmodule

`default_nettype wire

/* hw/rtl/integer_to_radix_ascii_core.sv */
// Top level of the integer-to-radix ASCII converter: sequencer, radix register, output port.
// Depends on i2ra_pkg, i2ra_divider and i2ra_digit_stack.
//
//   Channel   Direction  Handshake                 Payload
//   request   in         start / busy              req_value[30:0]
//   response  out        rsp_valid                 rsp_digit_char[6:0], rsp_last_digit
//   csr       in         csr_wr_en                 csr_wr_data[5:0] (radix)
//
// Operation: a value of n digits (1..31) keeps busy high while each digit costs one pass
//   of the shared divider (four quotient bits per cycle over a 32-bit word, plus a handoff),
//   then the digits stream out one per cycle.
// The last digit strobes in the first cycle after busy falls; a new request may start then.
// Reset: synchronous, active high; clears the sequencer and loads radix 10.
// Stalls: the receiver cannot stall; results leave one per cycle while rsp_valid is high.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_radix_ascii_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [i2ra_pkg::VALUE_BITS-1:0]     req_value,
   output logic                                     rsp_valid,
   output logic [i2ra_pkg::CHAR_BITS-1:0]           rsp_digit_char,
   output logic                                     rsp_last_digit,
   input  wire logic                                csr_wr_en,
   input  wire logic [i2ra_pkg::RADIX_BITS-1:0]     csr_wr_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_EMIT   = 2'd2;

   logic [1:0]                       state_ff, state_in;
   logic [i2ra_pkg::RADIX_BITS-1:0]  radix_ff;
   logic [i2ra_pkg::RADIX_BITS-1:0]  divisor_ff, divisor_in;

   logic                             div_start;
   logic [i2ra_pkg::WORK_BITS-1:0]   div_dividend;
   i2ra_pkg::div_result_type         div_res;

   logic                             push;
   logic                             pop;
   logic [i2ra_pkg::COUNT_BITS-1:0]  stack_count;
   i2ra_pkg::stack_read_type         stack_rd;

   // Radix register; clamped only when a request is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= i2ra_pkg::RADIX_RESET;
      end else if (csr_wr_en) begin
         radix_ff <= csr_wr_data;
      end
   end

   // Sequencer: divide until the quotient reaches zero, then drain the stack.
   // A zero value still takes one division, which leaves the single digit zero.
   always_comb begin
      state_in     = state_ff;
      divisor_in   = divisor_ff;
      div_start    = 1'b0;
      div_dividend = i2ra_pkg::WORK_BITS'(req_value);
      push         = 1'b0;
      pop          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               divisor_in = i2ra_pkg::effective_radix(radix_ff);
               div_start  = 1'b1;
               state_in   = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_res.done) begin
               push = 1'b1;
               if (div_res.quotient == '0) begin
                  state_in = ST_EMIT;
               end else begin
                  // Feed the quotient straight back for the next digit.
                  div_start    = 1'b1;
                  div_dividend = div_res.quotient;
               end
            end
         end
         ST_EMIT: begin
            pop = (stack_count != '0);
            if (stack_count == i2ra_pkg::COUNT_BITS'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
   end

   i2ra_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (divisor_in),
      .result   (div_res)
   );

   i2ra_digit_stack u_stack (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_digit (div_res.remainder),
      .pop        (pop),
      .count      (stack_count),
      .rd         (stack_rd)
   );

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = stack_rd.valid;
   assign rsp_digit_char = i2ra_pkg::digit_to_ascii(stack_rd.digit);
   assign rsp_last_digit = stack_rd.last;

   // Results only come out of the drain phase.
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_EMIT))
      else $error("result strobe outside drain phase");

   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_last_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last_digit |-> rsp_valid)
      else $error("last-digit flag without a result strobe");

endmodule

`default_nettype wire
